// File: rtl/spl_pkg.sv
// Shared types, constants and codes for the sorted priority list.
package spl_pkg;

  localparam int CAPACITY   = 128;
  localparam int KEY_W      = 64;
  localparam int PRIO_W     = 3;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY) + 1;

  // Fixed port widths of the request and response fields.
  localparam int KEY_PORT_W = 64;
  localparam int IDX_PORT_W = 7;
  localparam int CNT_PORT_W = 8;
  localparam int STAT_W     = 3;

  localparam logic [PRIO_W-1:0] MIN_PRIORITY = PRIO_W'(1);
  localparam logic [PRIO_W-1:0] MAX_PRIORITY = PRIO_W'(5);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_BAD_PRIO  = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_BAD_INDEX = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_RM_CMP,
    ST_RM_SHIFT,
    ST_RD_WAIT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_e           status;
    logic [CNT_W-1:0]  count;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
  } result_t;

endpackage

// File: rtl/spl_store.sv
// Entry memory: one write port and one registered read port.
module spl_store
  import spl_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t mem_req_i,
  output entry_t   rdata_o
);

  entry_t mem_q [CAPACITY];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_req_i.re) begin
      rdata_q <= mem_q[mem_req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/spl_ctrl.sv
// Sequencer: walks the entry memory one position per cycle for insert and remove.
module spl_ctrl
  import spl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            req_type_i,
  input  logic [KEY_PORT_W-1:0] entry_key_i,
  input  logic [PRIO_W-1:0]     entry_priority_i,
  input  logic [IDX_PORT_W-1:0] read_index_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output result_t               res_o,
  output mem_req_t              mem_req_o,
  input  entry_t                rdata_i
);

  state_e              state_q, state_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [PRIO_W-1:0]   prio_q, prio_d;
  logic [IDX_W-1:0]    pos_q, pos_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  status_e             stat_q, stat_d;
  logic [KEY_W-1:0]    rkey_q, rkey_d;
  logic [PRIO_W-1:0]   rprio_q, rprio_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    prio_q  <= prio_d;
    pos_q   <= pos_d;
    stat_q  <= stat_d;
    rkey_q  <= rkey_d;
    rprio_q <= rprio_d;
  end

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    prio_d      = prio_q;
    pos_d       = pos_q;
    fill_d      = fill_q;
    stat_d      = stat_q;
    rkey_d      = rkey_q;
    rprio_d     = rprio_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_req_o   = '0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          key_d   = KEY_W'(entry_key_i);
          prio_d  = entry_priority_i;
          stat_d  = STAT_OK;
          rkey_d  = '0;
          rprio_d = '0;
          state_d = ST_RESP;
          unique case (req_e'(req_type_i))
            REQ_INSERT: begin
              if (fill_q >= CNT_W'(CAPACITY)) begin
                stat_d = STAT_FULL;
              end else if (entry_priority_i < MIN_PRIORITY ||
                           entry_priority_i > MAX_PRIORITY) begin
                stat_d = STAT_BAD_PRIO;
              end else begin
                pos_d = fill_q[IDX_W-1:0];
                if (fill_q == '0) begin
                  state_d = ST_INS_PUT;
                end else begin
                  mem_req_o.re    = 1'b1;
                  mem_req_o.raddr = IDX_W'(fill_q - CNT_W'(1));
                  state_d         = ST_INS_CMP;
                end
              end
            end
            REQ_REMOVE: begin
              if (fill_q == '0) begin
                stat_d = STAT_NOT_FOUND;
              end else begin
                pos_d           = '0;
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = '0;
                state_d         = ST_RM_CMP;
              end
            end
            REQ_READ: begin
              if (CNT_W'(read_index_i) < fill_q) begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = IDX_W'(read_index_i);
                state_d         = ST_RD_WAIT;
              end else begin
                stat_d = STAT_BAD_INDEX;
              end
            end
            default: ;
          endcase
        end
      end

      ST_INS_CMP: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pos_q;
        if (rdata_i.prio > prio_q) begin
          // shift the worse entry down one place and look further up
          mem_req_o.wdata = rdata_i;
          pos_d           = pos_q - IDX_W'(1);
          if (pos_q == IDX_W'(1)) begin
            state_d = ST_INS_PUT;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = pos_q - IDX_W'(2);
          end
        end else begin
          mem_req_o.wdata = '{key: key_q, prio: prio_q};
          fill_d          = fill_q + CNT_W'(1);
          state_d         = ST_RESP;
        end
      end

      ST_INS_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pos_q;
        mem_req_o.wdata = '{key: key_q, prio: prio_q};
        fill_d          = fill_q + CNT_W'(1);
        state_d         = ST_RESP;
      end

      ST_RM_CMP: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = pos_q + IDX_W'(1);
        if (rdata_i.key == key_q) begin
          if (CNT_W'(pos_q) + CNT_W'(1) < fill_q) begin
            state_d = ST_RM_SHIFT;
          end else begin
            fill_d  = fill_q - CNT_W'(1);
            state_d = ST_RESP;
          end
        end else if (CNT_W'(pos_q) + CNT_W'(1) < fill_q) begin
          pos_d = pos_q + IDX_W'(1);
        end else begin
          stat_d  = STAT_NOT_FOUND;
          state_d = ST_RESP;
        end
      end

      ST_RM_SHIFT: begin
        // close the gap: move the next entry up one place
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pos_q;
        mem_req_o.wdata = rdata_i;
        pos_d           = pos_q + IDX_W'(1);
        if (CNT_W'(pos_q) + CNT_W'(2) < fill_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = pos_q + IDX_W'(2);
        end else begin
          fill_d  = fill_q - CNT_W'(1);
          state_d = ST_RESP;
        end
      end

      ST_RD_WAIT: begin
        rkey_d  = rdata_i.key;
        rprio_d = rdata_i.prio;
        state_d = ST_RESP;
      end

      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign res_o = '{status: stat_q, count: fill_q, key: rkey_q, prio: rprio_q};

endmodule

// File: rtl/sorted_priority_list.sv
// Each request ends in ST_RESP, then the output register; a read passes
// ST_RD_WAIT, an insert shifts entries down in ST_INS_CMP (ST_INS_PUT puts it
// at the head), a remove walks ST_RM_CMP, ST_RM_SHIFT; a miss scans all entries.
// Throughput: one transaction at a time; the next is taken once the result has
// moved into the output register. The entry memory port paces each walk.
// Reset: rst_ni clears the sequencer, the entry count and the output valid.
module sorted_priority_list
  import spl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            req_type_i,
  input  logic [KEY_PORT_W-1:0] entry_key_i,
  input  logic [PRIO_W-1:0]     entry_priority_i,
  input  logic [IDX_PORT_W-1:0] read_index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STAT_W-1:0]     status_o,
  output logic [CNT_PORT_W-1:0] entry_count_o,
  output logic [KEY_PORT_W-1:0] out_key_o,
  output logic [PRIO_W-1:0]     out_priority_o
);

  mem_req_t mem_req;
  entry_t   rdata;
  result_t  res;
  logic     res_valid;
  logic     res_ready;

  logic                  out_valid_q;
  logic [STAT_W-1:0]     status_q;
  logic [CNT_PORT_W-1:0] count_q;
  logic [KEY_PORT_W-1:0] key_q;
  logic [PRIO_W-1:0]     prio_q;

  // Sequencer: decodes each transaction and walks the list in memory.
  spl_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .entry_key_i      (entry_key_i),
    .entry_priority_i (entry_priority_i),
    .read_index_i     (read_index_i),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .res_o            (res),
    .mem_req_o        (mem_req),
    .rdata_i          (rdata)
  );

  // Entry storage, ordered by priority from position zero.
  spl_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

  // Output register: load when empty or when the held result is taken.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      status_q <= res.status;
      count_q  <= CNT_PORT_W'(res.count);
      key_q    <= KEY_PORT_W'(res.key);
      prio_q   <= res.prio;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign entry_count_o  = count_q;
  assign out_key_o      = key_q;
  assign out_priority_o = prio_q;

endmodule

// File: dv/sorted_priority_list_test.sv
// Self-checking testbench for the sorted priority list: random and directed requests vs a predictor.
`timescale 1ns / 100ps

module sorted_priority_list_test;
  import spl_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RAND_ITEMS   = 300;          // random requests per idling phase
  localparam int HOLD_LEN     = 400;          // long receiver hold-off, in cycles
  localparam int TAIL_CYCLES  = 300;          // tail run after the last phase, in cycles
  localparam int MAX_PRINTED  = 100;
  localparam int TIMEOUT_NS   = 50_000_000;
  localparam int POOL_SIZE    = 8;

  typedef struct packed {
    req_e                  kind;
    logic [KEY_PORT_W-1:0] key;
    logic [PRIO_W-1:0]     prio;
    logic [IDX_PORT_W-1:0] index;
  } list_request_t;

  typedef struct packed {
    status_e               status;
    logic [CNT_PORT_W-1:0] count;
    logic [KEY_PORT_W-1:0] key;
    logic [PRIO_W-1:0]     prio;
  } list_reply_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          out_valid;
  logic          out_ready = 1'b0;
  list_request_t offered = '{kind: REQ_INSERT, key: '0, prio: '0, index: '0};
  logic [STAT_W-1:0]     status;
  logic [CNT_PORT_W-1:0] entry_count;
  logic [KEY_PORT_W-1:0] out_key;
  logic [PRIO_W-1:0]     out_priority;

  // Requests waiting to be offered, and replies owed by the block in order.
  list_request_t requests_todo[$];
  list_reply_t   replies_due[$];

  // Predicted contents of the list.
  logic [KEY_W-1:0]  sim_keys[CAPACITY];
  logic [PRIO_W-1:0] sim_prios[CAPACITY];
  int unsigned       sim_fill = 0;

  // Keys the generator believes are held; order is irrelevant, only membership and count.
  logic [KEY_PORT_W-1:0] held_keys[$];
  logic [KEY_PORT_W-1:0] key_pool[POOL_SIZE];
  bit                    growing = 1'b1;
  int unsigned           at_limit = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_cnt;
  int unsigned error_count = 0;

  sorted_priority_list uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .req_type_i       (offered.kind),
    .entry_key_i      (offered.key),
    .entry_priority_i (offered.prio),
    .read_index_i     (offered.index),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .entry_count_o    (entry_count),
    .out_key_o        (out_key),
    .out_priority_o   (out_priority)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Count and print one mismatch; cap the printing so a broken block cannot flood the log.
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Apply one request to the predicted list and return the reply it owes.
  function automatic list_reply_t apply_list_request(input list_request_t rq);
    list_reply_t      rsp;
    int unsigned      pos;
    logic [KEY_W-1:0] key;
    rsp.status = STAT_OK;
    rsp.count  = '0;
    rsp.key    = '0;
    rsp.prio   = '0;
    key = rq.key[KEY_W-1:0];
    case (rq.kind)
      REQ_INSERT: begin
        // Full wins over a bad priority.
        if (sim_fill >= CAPACITY) begin
          rsp.status = STAT_FULL;
        end else if (rq.prio < MIN_PRIORITY || rq.prio > MAX_PRIORITY) begin
          rsp.status = STAT_BAD_PRIO;
        end else begin
          // Slide worse-priority entries down; stop behind equal or better ones.
          pos = sim_fill;
          while (pos > 0 && sim_prios[pos-1] > rq.prio) begin
            sim_keys[pos]  = sim_keys[pos-1];
            sim_prios[pos] = sim_prios[pos-1];
            pos--;
          end
          sim_keys[pos]  = key;
          sim_prios[pos] = rq.prio;
          sim_fill++;
        end
      end
      REQ_REMOVE: begin
        // Take the first match from the head and close the gap.
        pos = 0;
        while (pos < sim_fill && sim_keys[pos] != key) pos++;
        if (pos == sim_fill) begin
          rsp.status = STAT_NOT_FOUND;
        end else begin
          for (; pos + 1 < sim_fill; pos++) begin
            sim_keys[pos]  = sim_keys[pos+1];
            sim_prios[pos] = sim_prios[pos+1];
          end
          sim_fill--;
        end
      end
      REQ_READ: begin
        if (rq.index < sim_fill) begin
          rsp.key  = KEY_PORT_W'(sim_keys[rq.index]);
          rsp.prio = sim_prios[rq.index];
        end else begin
          rsp.status = STAT_BAD_INDEX;
        end
      end
      default: ;  // no-op request: only the count comes back
    endcase
    rsp.count = CNT_PORT_W'(sim_fill);
    return rsp;
  endfunction

  function automatic logic [KEY_PORT_W-1:0] any_key();
    return {$urandom(), $urandom()};
  endfunction

  // Queue one request and track which keys the list should hold afterwards.
  task automatic post_request(input req_e kind, input logic [KEY_PORT_W-1:0] key,
                              input logic [PRIO_W-1:0] prio,
                              input logic [IDX_PORT_W-1:0] index);
    int unsigned i;
    requests_todo.push_back('{kind: kind, key: key, prio: prio, index: index});
    if (kind == REQ_INSERT && held_keys.size() < CAPACITY &&
        prio >= MIN_PRIORITY && prio <= MAX_PRIORITY) begin
      held_keys.push_back(key);
    end else if (kind == REQ_REMOVE) begin
      for (i = 0; i < held_keys.size(); i++) begin
        if (held_keys[i] == key) begin
          held_keys.delete(i);
          break;
        end
      end
    end
  endtask

  // Sweep the list between empty and full: grow with mostly inserts, shrink with mostly
  // removes of held keys, switching after lingering a few requests at either limit.
  task automatic post_random_request();
    int unsigned           n;
    int unsigned           roll;
    req_e                  kind;
    logic [KEY_PORT_W-1:0] key;
    logic [PRIO_W-1:0]     prio;
    logic [IDX_PORT_W-1:0] index;
    n = held_keys.size();
    if (growing && n == CAPACITY) begin
      at_limit++;
      if (at_limit >= 6) begin
        growing  = 1'b0;
        at_limit = 0;
      end
    end else if (!growing && n == 0) begin
      at_limit++;
      if (at_limit >= 4) begin
        growing  = 1'b1;
        at_limit = 0;
      end
    end
    roll = $urandom_range(99);
    if (roll < (growing ? 60 : 15)) kind = REQ_INSERT;
    else if (roll < (growing ? 75 : 70)) kind = REQ_REMOVE;
    else if (roll < 97) kind = REQ_READ;
    else kind = REQ_NONE;
    roll = $urandom_range(99);
    if (kind == REQ_REMOVE && n != 0 && roll < 80) key = held_keys[$urandom_range(n - 1)];
    else if (roll < 40) key = key_pool[$urandom_range(POOL_SIZE - 1)];
    else if (roll < 55 && n != 0) key = held_keys[$urandom_range(n - 1)];
    else key = any_key();
    if ($urandom_range(9) == 0) prio = PRIO_W'($urandom());
    else prio = PRIO_W'($urandom_range(MAX_PRIORITY, MIN_PRIORITY));
    if ($urandom_range(3) == 0) index = IDX_PORT_W'($urandom());
    else index = IDX_PORT_W'($urandom_range(n < 127 ? n : 127));
    post_request(kind, key, prio, index);
  endtask

  // Hold until every queued request is accepted and answered; sample on falling edges so
  // the driver and monitor updates of the rising edge have settled.
  task automatic drain();
    while (requests_todo.size() != 0 || in_valid || replies_due.size() != 0) begin
      @(negedge clk);
    end
    @(negedge clk);
  endtask

  // Sender: offer the next pending request whenever the slot frees, unless idling this cycle.
  always @(posedge clk or negedge rst_n) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        replies_due.push_back(apply_list_request(offered));
      end
      if (!in_valid || in_ready) begin
        if (requests_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered  <= requests_todo.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Count the long hold-off; it ends by itself once hold_cnt reaches HOLD_LEN.
  always @(posedge clk or negedge rst_n) begin : hold_timer
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (!hold_req) begin
      hold_cnt <= 0;
    end else if (hold_cnt != HOLD_LEN) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  // Receiver: check each reply transaction against the oldest one owed, then pick ready.
  always @(posedge clk or negedge rst_n) begin : monitor
    list_reply_t due;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("reply with no request outstanding");
        end else begin
          due = replies_due.pop_front();
          if (status !== due.status)
            report_mismatch($sformatf("status %0d, want %0d", status, due.status));
          if (entry_count !== due.count)
            report_mismatch($sformatf("entry_count %0d, want %0d", entry_count, due.count));
          if (out_key !== due.key)
            report_mismatch($sformatf("out_key %h, want %h", out_key, due.key));
          if (out_priority !== due.prio)
            report_mismatch($sformatf("out_priority %0d, want %0d", out_priority, due.prio));
        end
      end
      out_ready <= !(hold_req && hold_cnt != HOLD_LEN) &&
                   $urandom_range(99) >= recv_stall_pct;
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned i;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < POOL_SIZE; i++) key_pool[i] = any_key();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty-list misses, bad priorities, ordering on ties, duplicate keys,
    // a no-op request, reads across and past the end, and removal at head and tail.
    post_request(REQ_READ,   key_pool[1], '0, '0);
    post_request(REQ_REMOVE, key_pool[0], '0, '0);
    post_request(REQ_INSERT, key_pool[1], 3'd0, '0);
    post_request(REQ_INSERT, key_pool[2], 3'd6, '0);
    post_request(REQ_INSERT, key_pool[2], 3'd7, '1);
    post_request(REQ_INSERT, key_pool[2], 3'd3, '0);
    post_request(REQ_INSERT, key_pool[3], 3'd3, '0);
    post_request(REQ_INSERT, key_pool[1], MAX_PRIORITY, '0);
    post_request(REQ_INSERT, key_pool[0], MIN_PRIORITY, '0);
    post_request(REQ_INSERT, key_pool[2], 3'd2, '0);
    post_request(REQ_INSERT, key_pool[4], 3'd4, '0);
    post_request(REQ_NONE,   key_pool[1], '1, '1);
    for (i = 0; i <= 6; i++) post_request(REQ_READ, any_key(), '1, IDX_PORT_W'(i));
    post_request(REQ_READ,   '0, '0, '1);
    post_request(REQ_REMOVE, key_pool[2], '0, '0);
    post_request(REQ_REMOVE, key_pool[2], '1, '1);
    post_request(REQ_REMOVE, key_pool[2], '0, '0);
    post_request(REQ_READ,   '0, '0, 7'd1);
    post_request(REQ_REMOVE, key_pool[1], '0, '0);
    post_request(REQ_REMOVE, key_pool[0], '0, '0);
    drain();

    // Random: no idling (with one long receiver hold-off), sender idle, receiver
    // stalling, then both.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_req = 1'b1; end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (i = 0; i < RAND_ITEMS; i++) post_random_request();
      drain();
      hold_req = 1'b0;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (replies_due.size() != 0) begin
      report_mismatch($sformatf("%0d replies never arrived", replies_due.size()));
    end
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
rtl/spl_pkg.sv
rtl/spl_store.sv
rtl/spl_ctrl.sv
rtl/sorted_priority_list.sv
dv/sorted_priority_list_test.sv
